FILE: src/point_in_polyhedron_level_set_assert.svh
// ----------------------------------------------------------------------------
// point_in_polyhedron_level_set assertion macros
// shared property forms for the level-set block checks
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYHEDRON_LEVEL_SET_ASSERT_SVH
`define POINT_IN_POLYHEDRON_LEVEL_SET_ASSERT_SVH

// same-cycle implication
`define PIPS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PIPS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/pips_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pips_pkg
// shared types and constants of the point-in-polyhedron level-set block
// ----------------------------------------------------------------------------
package pips_pkg;

   // default store sizes
   localparam int MAX_CORNERS_DEF = 8;
   localparam int MAX_FACES_DEF   = 8;

   // request queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // reset values of the configuration registers
   localparam logic [3:0]  FACES_RST = 4'd6;
   localparam logic [15:0] TOL_RST   = 16'd1;

   // configuration register indexes
   localparam logic REG_FACES = 1'b0;
   localparam logic REG_TOL   = 1'b1;

   // determinant roles within one tetrahedron
   localparam logic [2:0] DET_TOTAL = 3'd0;
   localparam logic [2:0] DET_A     = 3'd1;
   localparam logic [2:0] DET_B     = 3'd2;
   localparam logic [2:0] DET_C     = 3'd3;
   localparam logic [2:0] DET_D     = 3'd4;

   // level limits
   localparam logic signed [63:0] LEVEL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] LEVEL_MIN = 64'sh8000_0000_0000_0000;

   typedef enum logic [1:0] {
      CMD_CORNER = 2'd0,
      CMD_FACE   = 2'd1,
      CMD_CENTER = 2'd2,
      CMD_QUERY  = 2'd3
   } pips_cmd_type;

   typedef struct packed {
      logic signed [15:0] z;
      logic signed [15:0] y;
      logic signed [15:0] x;
   } pips_pt_type;

   // corner indexes, entry 0 is the apex
   typedef logic [3:0][2:0] pips_face_type;

   typedef struct packed {
      pips_cmd_type  cmd;
      logic [2:0]    slot;
      pips_pt_type   pt;
      pips_face_type face;
   } pips_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } pips_qstat_type;

   typedef struct packed {
      logic [2:0] k;
      logic       last;
   } pips_tag_type;

   typedef struct packed {
      logic [2:0] k;
      logic       deg;
      logic       last;
   } pips_ptag_type;

   typedef struct packed {
      logic               deg;
      logic               hit;
      logic signed [63:0] level;
   } pips_res_type;

endpackage

FILE: src/pips_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pips_front
// accepts requests, decodes the command and fields, hands them to the queue
// ----------------------------------------------------------------------------
module pips_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [63:0]              req_tdata,
   input  logic [1:0]               req_tuser,
   input  pips_pkg::pips_qstat_type q_st,
   output logic                     push_valid,
   output pips_pkg::pips_item_type  push_item
);

   logic                    valid_ff, valid_in;
   pips_pkg::pips_item_type item_ff, item_in;
   logic                    accept, moved;

   // one holding register, refilled as it drains
   assign moved      = valid_ff && !q_st.full;
   assign req_tready = !valid_ff || moved;
   assign accept     = req_tvalid && req_tready;
   assign push_valid = moved;
   assign push_item  = item_ff;

   // field decode
   always_comb begin
      item_in      = item_ff;
      valid_in     = moved ? 1'b0 : valid_ff;
      if (accept) begin
         item_in.cmd  = pips_pkg::pips_cmd_type'(req_tuser);
         item_in.slot = req_tdata[2:0];
         item_in.pt.x = req_tdata[18:3];
         item_in.pt.y = req_tdata[34:19];
         item_in.pt.z = req_tdata[50:35];
         item_in.face = req_tdata[62:51];
         valid_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

FILE: src/pips_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pips_queue
// short request queue between the front and the back
// ----------------------------------------------------------------------------
module pips_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  pips_pkg::pips_item_type  push_item,
   input  logic                     pop,
   output pips_pkg::pips_item_type  head,
   output pips_pkg::pips_qstat_type q_st
);

   localparam int QAW  = (pips_pkg::QUEUE_DEPTH > 1) ? $clog2(pips_pkg::QUEUE_DEPTH) : 1;
   localparam int CNTW = $clog2(pips_pkg::QUEUE_DEPTH + 1);

   pips_pkg::pips_item_type slot_ff [pips_pkg::QUEUE_DEPTH];
   logic [QAW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;

   assign head       = slot_ff[rd_ff];
   assign q_st.full  = (32'(cnt_ff) == pips_pkg::QUEUE_DEPTH);
   assign q_st.empty = (cnt_ff == '0);

   // pointer and fill count
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (32'(wr_ff) == pips_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ff + QAW'(1);
      end
      if (pop) begin
         rd_in = (32'(rd_ff) == pips_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ff + QAW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNTW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

endmodule

FILE: src/pips_det.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pips_det
// five-stage pipeline for the triple product (q-p).((r-p)x(s-p))
// ----------------------------------------------------------------------------
module pips_det (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  pips_pkg::pips_tag_type in_tag,
   input  pips_pkg::pips_pt_type  p,
   input  pips_pkg::pips_pt_type  q,
   input  pips_pkg::pips_pt_type  r,
   input  pips_pkg::pips_pt_type  s,
   output logic                   out_valid,
   output pips_pkg::pips_tag_type out_tag,
   output logic signed [53:0]     out_det
);

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   pips_pkg::pips_tag_type t1_ff, t2_ff, t3_ff, t4_ff, t5_ff;

   logic signed [16:0] ux_ff, uy_ff, uz_ff, vx_ff, vy_ff, vz_ff, wx_ff, wy_ff, wz_ff;
   logic signed [16:0] ux2_ff, uy2_ff, uz2_ff, ux3_ff, uy3_ff, uz3_ff;
   logic signed [33:0] m0_ff, m1_ff, m2_ff, m3_ff, m4_ff, m5_ff;
   logic signed [34:0] c0_ff, c1_ff, c2_ff;
   logic signed [51:0] e0_ff, e1_ff, e2_ff;
   logic signed [53:0] det_ff;

   // sign-extended difference of two coordinates
   function automatic logic signed [16:0] diff(input logic signed [15:0] a,
                                              input logic signed [15:0] b);
      diff = $signed({a[15], a}) - $signed({b[15], b});
   endfunction

   assign out_valid = v5_ff;
   assign out_tag   = t5_ff;
   assign out_det   = det_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      // edge vectors
      t1_ff  <= in_tag;
      ux_ff  <= diff(q.x, p.x);
      uy_ff  <= diff(q.y, p.y);
      uz_ff  <= diff(q.z, p.z);
      vx_ff  <= diff(r.x, p.x);
      vy_ff  <= diff(r.y, p.y);
      vz_ff  <= diff(r.z, p.z);
      wx_ff  <= diff(s.x, p.x);
      wy_ff  <= diff(s.y, p.y);
      wz_ff  <= diff(s.z, p.z);
      // cross product terms
      t2_ff  <= t1_ff;
      ux2_ff <= ux_ff;
      uy2_ff <= uy_ff;
      uz2_ff <= uz_ff;
      m0_ff  <= vy_ff * wz_ff;
      m1_ff  <= vz_ff * wy_ff;
      m2_ff  <= vz_ff * wx_ff;
      m3_ff  <= vx_ff * wz_ff;
      m4_ff  <= vx_ff * wy_ff;
      m5_ff  <= vy_ff * wx_ff;
      // cross product
      t3_ff  <= t2_ff;
      ux3_ff <= ux2_ff;
      uy3_ff <= uy2_ff;
      uz3_ff <= uz2_ff;
      c0_ff  <= 35'(m0_ff) - 35'(m1_ff);
      c1_ff  <= 35'(m2_ff) - 35'(m3_ff);
      c2_ff  <= 35'(m4_ff) - 35'(m5_ff);
      // dot product terms
      t4_ff  <= t3_ff;
      e0_ff  <= ux3_ff * c0_ff;
      e1_ff  <= uy3_ff * c1_ff;
      e2_ff  <= uz3_ff * c2_ff;
      // sum
      t5_ff  <= t4_ff;
      det_ff <= 54'(e0_ff) + 54'(e1_ff) + 54'(e2_ff);
   end

endmodule

FILE: src/pips_prod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pips_prod
// exact product of the total determinant with each corner determinant,
// scaled by 2^-20 with floor rounding and saturated to 64 bits
// ----------------------------------------------------------------------------
module pips_prod (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  pips_pkg::pips_tag_type  in_tag,
   input  logic signed [53:0]      in_det,
   output logic                    out_valid,
   output pips_pkg::pips_ptag_type out_tag,
   output logic signed [63:0]      out_pr
);

   logic signed [53:0] d0_ff;
   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   pips_pkg::pips_ptag_type t1_ff, t2_ff, t3_ff, t4_ff, t1_in;
   logic [53:0]  a_ff, b_ff, a_in, b_in;
   logic         sg1_ff, sg2_ff, sg3_ff;
   logic [53:0]  pll_ff, plh_ff, phl_ff, phh_ff;
   logic [107:0] mag_ff;
   logic signed [63:0]  pr_ff, pr_in;
   logic signed [108:0] sv, sh;
   logic               issue;

   assign issue     = in_valid && (in_tag.k != pips_pkg::DET_TOTAL);
   assign out_valid = v4_ff;
   assign out_tag   = t4_ff;
   assign out_pr    = pr_ff;

   // magnitudes and tag of the next product
   always_comb begin
      a_in       = d0_ff[53] ? 54'(-d0_ff) : 54'(d0_ff);
      b_in       = in_det[53] ? 54'(-in_det) : 54'(in_det);
      t1_in.k    = in_tag.k;
      t1_in.deg  = (d0_ff == '0);
      t1_in.last = in_tag.last;
   end

   // signed result, floor shift and saturation
   always_comb begin
      sv = sg3_ff ? -$signed({1'b0, mag_ff}) : $signed({1'b0, mag_ff});
      sh = sv >>> 20;
      if ((&sh[108:63]) || !(|sh[108:63])) begin
         pr_in = sh[63:0];
      end else begin
         pr_in = sh[108] ? pips_pkg::LEVEL_MIN : pips_pkg::LEVEL_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      // total determinant held for the four products that follow
      if (in_valid && in_tag.k == pips_pkg::DET_TOTAL) begin
         d0_ff <= in_det;
      end
      t1_ff  <= t1_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      sg1_ff <= d0_ff[53] ^ in_det[53];
      // partial products
      t2_ff  <= t1_ff;
      sg2_ff <= sg1_ff;
      pll_ff <= a_ff[26:0] * b_ff[26:0];
      plh_ff <= a_ff[26:0] * b_ff[53:27];
      phl_ff <= a_ff[53:27] * b_ff[26:0];
      phh_ff <= a_ff[53:27] * b_ff[53:27];
      // exact magnitude
      t3_ff  <= t2_ff;
      sg3_ff <= sg2_ff;
      mag_ff <= (108'(phh_ff) << 54) + (108'(plh_ff) << 27) + (108'(phl_ff) << 27)
                + 108'(pll_ff);
      // scaled value
      t4_ff  <= t3_ff;
      pr_ff  <= pr_in;
   end

endmodule

FILE: src/pips_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pips_back
// executes queued requests: store and center loads, and the per-face walk of a query
// through the determinant and product pipelines, with the level reduction
// ----------------------------------------------------------------------------
module pips_back #(
   parameter int MAX_CORNERS = pips_pkg::MAX_CORNERS_DEF,
   parameter int MAX_FACES   = pips_pkg::MAX_FACES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  pips_pkg::pips_item_type  q_item,
   input  pips_pkg::pips_qstat_type q_st,
   output logic                     q_pop,
   input  logic [3:0]               faces_in_use,
   input  logic [15:0]              inside_tolerance,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output pips_pkg::pips_res_type   rsp_res
);

   localparam int CIW = $clog2(MAX_CORNERS);
   localparam int FIW = $clog2(MAX_FACES);
   localparam int NW  = $clog2(MAX_FACES + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FACE,
      ST_CRN,
      ST_ISSUE,
      ST_WAIT,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic [FIW-1:0] f_ff, f_in;
   logic [2:0]     ci_ff, ci_in, k_ff, k_in;
   logic           ti_ff, ti_in;
   logic           out_valid_ff, out_valid_in;
   logic           fin_ff, fin_in, done_ff, done_in;
   pips_pkg::pips_pt_type  center_ff, center_in, qpt_ff, qpt_in;
   pips_pkg::pips_pt_type  crn_ff [4];
   pips_pkg::pips_pt_type  crn_in [4];
   pips_pkg::pips_res_type out_res_ff, out_res_in;

   // reduction state
   logic               tin_ff, tin_in, inside_ff, inside_in, deg_ff, deg_in;
   logic signed [63:0] tmax_ff, tmax_in, level_ff, level_in;
   logic signed [63:0] thr, cur_max, tv;
   logic               cur_in;

   // stores
   pips_pkg::pips_pt_type   corner_mem [MAX_CORNERS];
   pips_pkg::pips_face_type face_mem [MAX_FACES];
   pips_pkg::pips_pt_type   crn_rd_ff;
   pips_pkg::pips_face_type face_rd_ff;
   logic                    crn_oor_ff;
   logic                    crn_we, face_we;
   logic [CIW-1:0]          crn_ra;
   logic [2:0]              crn_idx;

   // walk limits
   logic [NW-1:0] n_faces;
   logic          last_face;

   // pipelines
   logic                    det_valid, det_out_valid, pr_valid;
   pips_pkg::pips_tag_type  det_tag, det_out_tag;
   pips_pkg::pips_ptag_type pr_tag;
   pips_pkg::pips_pt_type   dp, dq, dr, ds, p1, p2, p3;
   logic signed [53:0]      det_out;
   logic signed [63:0]      pr;

   assign n_faces   = (32'(faces_in_use) > MAX_FACES) ? NW'(MAX_FACES) : NW'(faces_in_use);
   assign last_face = (32'(f_ff) + 1 == 32'(n_faces));
   assign crn_idx   = face_rd_ff[ci_ff[1:0]];
   assign crn_ra    = CIW'(crn_idx);
   assign rsp_valid = out_valid_ff;
   assign rsp_res   = out_res_ff;

   // store writes and registered reads
   always_ff @(posedge clock) begin
      if (crn_we) begin
         corner_mem[CIW'(q_item.slot)] <= q_item.pt;
      end
      if (face_we) begin
         face_mem[FIW'(q_item.slot)] <= q_item.face;
      end
      crn_rd_ff  <= corner_mem[crn_ra];
      crn_oor_ff <= (32'(crn_idx) >= MAX_CORNERS);
      face_rd_ff <= face_mem[f_ff];
   end

   // tetrahedron corners and determinant operands
   always_comb begin
      p1      = crn_ff[0];
      p2      = ti_ff ? crn_ff[2] : crn_ff[1];
      p3      = ti_ff ? crn_ff[3] : crn_ff[2];
      dp      = p1;
      dq      = p2;
      dr      = p3;
      ds      = center_ff;
      case (k_ff)
         pips_pkg::DET_TOTAL: begin
         end
         pips_pkg::DET_A: dp = qpt_ff;
         pips_pkg::DET_B: dq = qpt_ff;
         pips_pkg::DET_C: dr = qpt_ff;
         pips_pkg::DET_D: ds = qpt_ff;
         default: begin
         end
      endcase
      det_tag.k    = k_ff;
      det_tag.last = last_face && ti_ff && (k_ff == pips_pkg::DET_D);
   end

   // sequencer and reduction
   always_comb begin
      state_in     = state_ff;
      f_in         = f_ff;
      ci_in        = ci_ff;
      k_in         = k_ff;
      ti_in        = ti_ff;
      center_in    = center_ff;
      qpt_in       = qpt_ff;
      crn_in       = crn_ff;
      out_res_in   = out_res_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      q_pop        = 1'b0;
      crn_we       = 1'b0;
      face_we      = 1'b0;
      det_valid    = 1'b0;
      tin_in       = tin_ff;
      tmax_in      = tmax_ff;
      inside_in    = inside_ff;
      deg_in       = deg_ff;
      level_in     = level_ff;
      done_in      = done_ff;
      fin_in       = 1'b0;
      cur_in       = 1'b0;
      cur_max      = '0;
      tv           = '0;
      thr          = -$signed({48'b0, inside_tolerance});

      case (state_ff)
         ST_IDLE: begin
            if (!q_st.empty) begin
               q_pop = 1'b1;
               case (q_item.cmd)
                  pips_pkg::CMD_CORNER: crn_we = (32'(q_item.slot) < MAX_CORNERS);
                  pips_pkg::CMD_FACE:   face_we = (32'(q_item.slot) < MAX_FACES);
                  pips_pkg::CMD_CENTER: center_in = q_item.pt;
                  pips_pkg::CMD_QUERY: begin
                     qpt_in    = q_item.pt;
                     f_in      = '0;
                     ti_in     = 1'b0;
                     k_in      = pips_pkg::DET_TOTAL;
                     inside_in = 1'b0;
                     deg_in    = 1'b0;
                     level_in  = pips_pkg::LEVEL_MAX;
                     done_in   = 1'b0;
                     state_in  = (n_faces == '0) ? ST_OUT : ST_FACE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FACE: begin
            ci_in    = '0;
            state_in = ST_CRN;
         end
         ST_CRN: begin
            // corner read data is registered and arrives in the cycle after its address
            if (ci_ff != '0) begin
               crn_in[2'(ci_ff - 3'd1)] = crn_oor_ff ? '0 : crn_rd_ff;
            end
            if (ci_ff == 3'd4) begin
               state_in = ST_ISSUE;
            end else begin
               ci_in = ci_ff + 3'd1;
            end
         end
         ST_ISSUE: begin
            det_valid = 1'b1;
            if (k_ff == pips_pkg::DET_D) begin
               k_in = pips_pkg::DET_TOTAL;
               if (!ti_ff) begin
                  ti_in = 1'b1;
               end else begin
                  ti_in = 1'b0;
                  if (last_face) begin
                     state_in = ST_WAIT;
                  end else begin
                     f_in     = f_ff + FIW'(1);
                     state_in = ST_FACE;
                  end
               end
            end else begin
               k_in = k_ff + 3'd1;
            end
         end
         ST_WAIT: begin
            if (fin_ff) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in     = 1'b1;
               out_res_in.hit   = inside_ff;
               out_res_in.deg   = deg_ff;
               out_res_in.level = level_ff;
               state_in         = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // per-tetrahedron max and inside test, then the level walk
      if (pr_valid) begin
         if (pr_tag.k == pips_pkg::DET_A) begin
            cur_in  = (pr >= thr);
            cur_max = pr;
         end else begin
            cur_in  = tin_ff && (pr >= thr);
            cur_max = (pr > tmax_ff) ? pr : tmax_ff;
         end
         tin_in  = cur_in;
         tmax_in = cur_max;
         if (pr_tag.k == pips_pkg::DET_D) begin
            if (pr_tag.deg) begin
               deg_in = 1'b1;
            end else begin
               if (cur_in) begin
                  tv        = -cur_max;
                  inside_in = 1'b1;
               end else if (cur_max < 0) begin
                  tv = (cur_max == pips_pkg::LEVEL_MIN) ? pips_pkg::LEVEL_MAX : -cur_max;
               end else begin
                  tv = cur_max;
               end
               if (!done_ff) begin
                  if (tv > 0) begin
                     if (tv < level_ff) begin
                        level_in = tv;
                     end
                  end else begin
                     level_in = tv;
                     done_in  = 1'b1;
                  end
               end
            end
            fin_in = pr_tag.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         f_ff         <= '0;
         ci_ff        <= '0;
         k_ff         <= pips_pkg::DET_TOTAL;
         ti_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
         fin_ff       <= 1'b0;
         done_ff      <= 1'b0;
         center_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         f_ff         <= f_in;
         ci_ff        <= ci_in;
         k_ff         <= k_in;
         ti_ff        <= ti_in;
         out_valid_ff <= out_valid_in;
         fin_ff       <= fin_in;
         done_ff      <= done_in;
         center_ff    <= center_in;
      end
   end

   always_ff @(posedge clock) begin
      qpt_ff     <= qpt_in;
      crn_ff     <= crn_in;
      out_res_ff <= out_res_in;
      tin_ff     <= tin_in;
      tmax_ff    <= tmax_in;
      inside_ff  <= inside_in;
      deg_ff     <= deg_in;
      level_ff   <= level_in;
   end

   pips_det u_det (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (det_valid),
      .in_tag    (det_tag),
      .p         (dp),
      .q         (dq),
      .r         (dr),
      .s         (ds),
      .out_valid (det_out_valid),
      .out_tag   (det_out_tag),
      .out_det   (det_out)
   );

   pips_prod u_prod (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (det_out_valid),
      .in_tag    (det_out_tag),
      .in_det    (det_out),
      .out_valid (pr_valid),
      .out_tag   (pr_tag),
      .out_pr    (pr)
   );

endmodule

FILE: src/point_in_polyhedron_level_set.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polyhedron_level_set
// Holds a convex polyhedron (corners, faces of four corner indices, center)
// loaded by command requests, and answers query requests with an inside flag,
// a degenerate flag and a signed level value, a determinant product scaled by
// 2^-20. Load requests give no response and are executed in the back end
// while it is idle. A query walks faces_in_use faces (capped at MAX_FACES);
// each face takes one face-store read, four corner-store reads through a
// single read port, and ten determinant issues into the shared pipelined
// datapath; the response follows the final drain through the determinant and
// product pipelines. Requests queue in front of the back end, and a finished
// response waits in an output register while new requests are taken.
// ----------------------------------------------------------------------------
`include "point_in_polyhedron_level_set_assert.svh"

module point_in_polyhedron_level_set #(
   parameter int MAX_CORNERS = pips_pkg::MAX_CORNERS_DEF,
   parameter int MAX_FACES   = pips_pkg::MAX_FACES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request: tdata = slot, coord_x, coord_y, coord_z, face_corner_a..d, pad
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,
   // request: tuser = command
   input  logic [1:0]  req_tuser,
   // response: tdata = level_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,
   // response: tuser = inside_res, degenerate
   output logic [1:0]  rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [3:0]  faces_ff;
   logic [15:0] tol_ff;
   logic        csr_wr;

   logic                     push_valid, q_pop;
   pips_pkg::pips_item_type  push_item, q_head;
   pips_pkg::pips_qstat_type q_st;
   pips_pkg::pips_res_type   res;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         faces_ff <= pips_pkg::FACES_RST;
         tol_ff   <= pips_pkg::TOL_RST;
      end else if (csr_wr) begin
         case (csr_paddr[2])
            pips_pkg::REG_FACES: faces_ff <= csr_pwdata[3:0];
            pips_pkg::REG_TOL:   tol_ff   <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         pips_pkg::REG_FACES: csr_prdata = {28'b0, faces_ff};
         pips_pkg::REG_TOL:   csr_prdata = {16'b0, tol_ff};
         default:             csr_prdata = '0;
      endcase
   end

   // response packing
   assign rsp_tdata = res.level;
   assign rsp_tuser = {res.deg, res.hit};

   pips_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_st       (q_st),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   pips_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_item (push_item),
      .pop       (q_pop),
      .head      (q_head),
      .q_st      (q_st)
   );

   pips_back #(
      .MAX_CORNERS (MAX_CORNERS),
      .MAX_FACES   (MAX_FACES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_item           (q_head),
      .q_st             (q_st),
      .q_pop            (q_pop),
      .faces_in_use     (faces_ff),
      .inside_tolerance (tol_ff),
      .rsp_ready        (rsp_tready),
      .rsp_valid        (rsp_tvalid),
      .rsp_res          (res)
   );

   // checks
   `PIPS_ASSERT_IMP(a_pop_nonempty, clock, reset, q_pop, !q_st.empty, "pop from empty queue")
   `PIPS_ASSERT_IMP(a_push_room, clock, reset, push_valid, !q_st.full, "push into full queue")
   `PIPS_ASSERT_NXT(a_req_held, clock, reset, !reset && req_tvalid && req_tready, !req_tready || push_valid || q_st.full, "accepted request lost")
   `PIPS_ASSERT_NXT(a_cfg_write, clock, reset, !reset && csr_wr && csr_paddr[2] == pips_pkg::REG_FACES, faces_ff == $past(csr_pwdata[3:0]), "faces register not written")

endmodule
